// File: sv/tcw_pkg.sv
// Shared constants, types and state encoding for the transitive closure block.
package tcw_pkg;

    // Graph size and field widths
    localparam int NODES  = 64;
    localparam int IDX_W  = 6;
    localparam int ROW_W  = 64;
    localparam int ADDR_W = $clog2(NODES);

    localparam logic [IDX_W-1:0] NODE_COUNT_RST = IDX_W'(63);
    localparam logic [IDX_W-1:0] TOP_LIMIT      = IDX_W'(NODES - 1);

    // Sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PIV_RD,
        ST_PIV_LAT,
        ST_SWEEP,
        ST_EMIT_RD,
        ST_EMIT_WAIT
    } t_state;

    // Sequencer to datapath controls
    typedef struct packed {
        logic             in_ready;
        logic             rd_en;
        logic [IDX_W-1:0] rd_row;
        logic             piv_load;
        logic             sweep_wr;
        logic [IDX_W-1:0] pivot;
        logic [IDX_W-1:0] row;
        logic             emit_load;
        logic             emit_last;
    } t_seq_ctl;

endpackage

// File: sv/tcw_ram.sv
// Generic single-write, single-read memory with registered read data.
module tcw_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/tcw_seq.sv
// Sequencer: walks load, pivot/row closure sweeps and row output.
module tcw_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_xfer,
    input  logic                  i_last_row,
    input  logic [tcw_pkg::IDX_W-1:0] i_top,
    input  logic                  i_out_free,
    output tcw_pkg::t_seq_ctl     o_ctl
);

    import tcw_pkg::*;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_k, n_k;
    logic [IDX_W-1:0] r_i, n_i;

    // Next state and counters
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_i     = r_i;
        case (r_state)
            ST_LOAD: begin
                if (i_in_xfer && i_last_row) begin
                    n_state = ST_PIV_RD;
                    n_k     = '0;
                end
            end
            ST_PIV_RD: begin
                n_state = ST_PIV_LAT;
            end
            ST_PIV_LAT: begin
                n_state = ST_SWEEP;
                n_i     = '0;
            end
            ST_SWEEP: begin
                if (r_i == i_top) begin
                    if (r_k == i_top) begin
                        n_state = ST_EMIT_RD;
                        n_i     = '0;
                    end else begin
                        n_state = ST_PIV_RD;
                        n_k     = r_k + 1'b1;
                    end
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            ST_EMIT_RD: begin
                if (i_out_free) begin
                    n_state = ST_EMIT_WAIT;
                end
            end
            ST_EMIT_WAIT: begin
                if (r_i == i_top) begin
                    n_state = ST_LOAD;
                end else begin
                    n_state = ST_EMIT_RD;
                    n_i     = r_i + 1'b1;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // Control outputs
    always_comb begin
        o_ctl           = '0;
        o_ctl.pivot     = r_k;
        o_ctl.row       = r_i;
        o_ctl.emit_last = (r_i == i_top);
        case (r_state)
            ST_LOAD: begin
                o_ctl.in_ready = 1'b1;
            end
            ST_PIV_RD: begin
                o_ctl.rd_en  = 1'b1;
                o_ctl.rd_row = r_k;
            end
            ST_PIV_LAT: begin
                o_ctl.piv_load = 1'b1;
                o_ctl.rd_en    = 1'b1;
                o_ctl.rd_row   = '0;
            end
            ST_SWEEP: begin
                o_ctl.sweep_wr = 1'b1;
                o_ctl.rd_en    = (r_i != i_top);
                o_ctl.rd_row   = r_i + 1'b1;
            end
            ST_EMIT_RD: begin
                o_ctl.rd_en  = i_out_free;
                o_ctl.rd_row = r_i;
            end
            ST_EMIT_WAIT: begin
                o_ctl.emit_load = 1'b1;
            end
            default: begin
                o_ctl.in_ready = 1'b0;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_k     <= '0;
            r_i     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_i     <= n_i;
        end
    end

endmodule

// File: sv/transitive_closure_warshall_top.sv
// Top level: Warshall transitive closure over a row memory with one shared OR unit.
// Load: one row transfer per cycle. After the last row, the closure runs over nodes 0..n,
// n = min(node_count, NODES-1): per pivot one read, one latch, n+1 row sweeps.
// Output: per closure row one read, then an output register load; a downstream stall holds the read.
// Input is stalled from the last row until the final row enters the output register.
// Synchronous active-low reset clears control and sets node_count to 63; rows are undefined.
module transitive_closure_warshall_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Configuration
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [tcw_pkg::IDX_W-1:0] i_cfg_node_count,
    // Input rows
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [tcw_pkg::IDX_W-1:0] i_row_index,
    input  logic [tcw_pkg::ROW_W-1:0] i_row_bits,
    input  logic                      i_last_row,
    // Closure rows
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [tcw_pkg::IDX_W-1:0] o_out_index,
    output logic [tcw_pkg::ROW_W-1:0] o_closure_row,
    output logic                      o_last_out
);

    import tcw_pkg::*;

    logic [IDX_W-1:0]  r_node_count;
    logic [IDX_W-1:0]  w_top;
    logic [ROW_W-1:0]  w_mask;
    logic              w_in_xfer;
    logic              w_out_free;
    t_seq_ctl          w_ctl;
    logic [ROW_W-1:0]  w_rdata;
    logic [ROW_W-1:0]  r_pivot;
    logic              w_mem_we;
    logic [ADDR_W-1:0] w_mem_waddr;
    logic [ROW_W-1:0]  w_mem_wdata;
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_index;
    logic [ROW_W-1:0]  r_out_row;
    logic              r_out_last;

    // Configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_node_count <= i_cfg_node_count;
        end
    end

    // Highest node in use and the column mask
    assign w_top = (r_node_count > TOP_LIMIT) ? TOP_LIMIT : r_node_count;

    always_comb begin
        for (int j = 0; j < ROW_W; j++) begin
            w_mask[j] = (j <= int'(w_top));
        end
    end

    // Handshakes
    assign o_in_stall = !w_ctl.in_ready;
    assign w_in_xfer  = i_in_valid && w_ctl.in_ready;
    assign w_out_free = !r_out_valid || !i_out_stall;

    tcw_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_xfer  (w_in_xfer),
        .i_last_row (i_last_row),
        .i_top      (w_top),
        .i_out_free (w_out_free),
        .o_ctl      (w_ctl)
    );

    // Memory write: row load, or the shared OR unit during a sweep
    always_comb begin
        if (w_ctl.in_ready) begin
            w_mem_we    = w_in_xfer && (i_row_index <= TOP_LIMIT);
            w_mem_waddr = i_row_index[ADDR_W-1:0];
            w_mem_wdata = i_row_bits & w_mask;
        end else begin
            w_mem_we    = w_ctl.sweep_wr && w_rdata[w_ctl.pivot];
            w_mem_waddr = w_ctl.row[ADDR_W-1:0];
            w_mem_wdata = (w_rdata | r_pivot) & w_mask;
        end
    end

    tcw_ram #(
        .DEPTH (NODES),
        .WIDTH (ROW_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_ctl.rd_en),
        .i_raddr (w_ctl.rd_row[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    // Pivot row latch
    always_ff @(posedge i_clk) begin
        if (w_ctl.piv_load) begin
            r_pivot <= w_rdata & w_mask;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.emit_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.emit_load) begin
            r_out_index <= w_ctl.row;
            r_out_row   <= w_rdata & w_mask;
            r_out_last  <= w_ctl.emit_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_index   = r_out_index;
    assign o_closure_row = r_out_row;
    assign o_last_out    = r_out_last;

    // Checks

    // A row only enters the output register if the previous one had left
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.emit_load |-> $past(w_out_free))
        else $error("closure row overwrote a pending output");

    // The final row carries the highest node in use
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_out) |-> (o_out_index == w_top))
        else $error("last row index does not match node count");

    // Closure writes stay inside the active node range
    a_sweep_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mem_we && !w_ctl.in_ready) |-> (w_ctl.row <= w_top))
        else $error("closure write outside active rows");

    // No input is taken while a closure or output pass is running
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_last_row) |=> o_in_stall)
        else $error("input accepted after last row");

endmodule

// File: dv/transitive_closure_warshall_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Warshall transitive closure block: directed table, random graphs.
module transitive_closure_warshall_top_tb;
    import tcw_pkg::*;

    localparam int RAND_ITEMS = 310;
    localparam int DRAIN_WAIT = 8;
    localparam int END_WAIT   = 40;
    localparam int LONG_HOLD  = 400;
    localparam int HOLD_AFTER = 100;
    localparam int DIR_ROWS   = 22;

    // One closure row as the block emits it
    typedef struct {
        logic [IDX_W-1:0] idx;
        logic [ROW_W-1:0] row;
        logic             last;
    } t_closure_row;

    // Directed stimulus row; every_row is typed in when all closure rows are equal
    typedef struct packed {
        logic [IDX_W-1:0] n;
        logic [IDX_W-1:0] idx;
        logic [ROW_W-1:0] bits;
        logic             last;
        logic             typed;
        logic [ROW_W-1:0] every_row;
    } t_directed_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [IDX_W-1:0] i_cfg_node_count;
    logic             i_in_valid;
    logic             o_in_stall;
    logic [IDX_W-1:0] i_row_index;
    logic [ROW_W-1:0] i_row_bits;
    logic             i_last_row;
    logic             o_out_valid;
    logic             i_out_stall;
    logic [IDX_W-1:0] o_out_index;
    logic [ROW_W-1:0] o_closure_row;
    logic             o_last_out;

    // Predictor state
    logic [ROW_W-1:0] reach [NODES];
    bit               row_loaded [NODES];
    logic [IDX_W-1:0] cur_n;
    t_closure_row     closure_q [$];
    t_closure_row     want_row;

    int errors;
    int results_seen;
    int items_sent;
    int send_calm;
    int recv_calm;
    int shut_left;
    int hold_left;
    bit hold_done;

    t_directed_row dir_tab [DIR_ROWS] = '{
        // single node: self loop survives, edge to node 1 is masked, row 63 stored unused
        '{6'd0,  6'd0,  '1,                     1'b1, 1'b1, 64'h1},
        '{6'd0,  6'd0,  '0,                     1'b1, 1'b1, 64'h0},
        '{6'd0,  6'd63, '1,                     1'b0, 1'b0, 64'h0},
        '{6'd0,  6'd0,  64'h2,                  1'b1, 1'b1, 64'h0},
        // two-node cycle, top bit masked off
        '{6'd1,  6'd0,  64'h2,                  1'b0, 1'b0, 64'h0},
        '{6'd1,  6'd1,  64'h8000_0000_0000_0001, 1'b1, 1'b1, 64'h3},
        '{6'd1,  6'd0,  64'h0,                  1'b0, 1'b0, 64'h0},
        '{6'd1,  6'd1,  '1,                     1'b1, 1'b0, 64'h0},
        // only row 1 reloaded, row 0 kept from the earlier graph
        '{6'd1,  6'd1,  64'h2,                  1'b1, 1'b0, 64'h0},
        // chain 0 -> 1 -> 2
        '{6'd2,  6'd2,  64'h0,                  1'b0, 1'b0, 64'h0},
        '{6'd2,  6'd1,  64'h4,                  1'b0, 1'b0, 64'h0},
        '{6'd2,  6'd0,  64'h2,                  1'b1, 1'b0, 64'h0},
        // three-node cycle: everything reaches everything
        '{6'd2,  6'd0,  64'h2,                  1'b0, 1'b0, 64'h0},
        '{6'd2,  6'd1,  64'h4,                  1'b0, 1'b0, 64'h0},
        '{6'd2,  6'd2,  64'h1,                  1'b1, 1'b1, 64'h7},
        // rows loaded in descending order, last mark on node 0
        '{6'd5,  6'd5,  64'hFFFF_FFFF_FFFF_FFC1, 1'b0, 1'b0, 64'h0},
        '{6'd5,  6'd4,  64'h20,                 1'b0, 1'b0, 64'h0},
        '{6'd5,  6'd3,  64'h10,                 1'b0, 1'b0, 64'h0},
        '{6'd5,  6'd2,  64'h8,                  1'b0, 1'b0, 64'h0},
        '{6'd5,  6'd1,  64'h0,                  1'b0, 1'b0, 64'h0},
        '{6'd5,  6'd0,  64'h4,                  1'b1, 1'b0, 64'h0},
        // last mark on a node outside the graph still starts a closure
        '{6'd5,  6'd40, 64'h1,                  1'b1, 1'b0, 64'h0}
    };

    transitive_closure_warshall_top i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_node_count (i_cfg_node_count),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_row_index      (i_row_index),
        .i_row_bits       (i_row_bits),
        .i_last_row       (i_last_row),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_index      (o_out_index),
        .o_closure_row    (o_closure_row),
        .o_last_out       (o_last_out)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Gap length: mostly short, a few long, with calm stretches of no gaps
    function automatic int pick_gap(inout int calm);
        int roll;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Row content: empty, full, dense or sparse; dense rows exercise the mask above top
    function automatic logic [ROW_W-1:0] random_row(input int top);
        logic [ROW_W-1:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: r = '0;
            1: r = '1;
            2, 3: ;
            default: begin
                r &= {$urandom, $urandom};
                r &= {$urandom, $urandom};
                if (top > 15) r &= {$urandom, $urandom};
            end
        endcase
        return r;
    endfunction

    // Count a mismatch and print one line for it
    task automatic report_mismatch(input string what, input logic [ROW_W-1:0] got,
                                   input logic [ROW_W-1:0] want);
        errors++;
        $display("[%0t] mismatch %s: got %h want %h", $time, what, got, want);
    endtask

    // Store one accepted row; a last mark runs the closure and queues the emitted rows
    task automatic warshall_closure(input logic [IDX_W-1:0] idx, input logic [ROW_W-1:0] bits,
                                    input logic last, input logic typed,
                                    input logic [ROW_W-1:0] every_row);
        int               top;
        int               k;
        int               i;
        logic [ROW_W-1:0] mask;
        logic [ROW_W-1:0] pivot;
        t_closure_row     r;
        top  = (int'(cur_n) > NODES - 1) ? NODES - 1 : int'(cur_n);
        mask = '1;
        if (top < ROW_W - 1) mask = ~(mask << (top + 1));
        if (int'(idx) < NODES) begin
            reach[idx]      = bits & mask;
            row_loaded[idx] = 1'b1;
        end
        if (last) begin
            for (k = 0; k <= top; k++) begin
                pivot = reach[k] & mask;
                for (i = 0; i <= top; i++)
                    if (reach[i][k]) reach[i] = (reach[i] | pivot) & mask;
            end
            for (i = 0; i <= top; i++) begin
                r.idx  = IDX_W'(i);
                r.row  = typed ? every_row : (reach[i] & mask);
                r.last = (i == top);
                closure_q.insert(closure_q.size(), r);
            end
        end
    endtask

    // One row transfer; entered and left at a falling edge
    task automatic send_row(input logic [IDX_W-1:0] idx, input logic [ROW_W-1:0] bits,
                            input logic last, input logic typed,
                            input logic [ROW_W-1:0] every_row);
        int gap;
        gap = pick_gap(send_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_row_index <= idx;
        i_row_bits  <= bits;
        i_last_row  <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        warshall_closure(idx, bits, last, typed, every_row);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Let all closure rows drain, then write node_count
    task automatic set_node_count(input logic [IDX_W-1:0] n);
        i_in_valid <= 1'b0;
        while (closure_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        i_cfg_valid      <= 1'b1;
        i_cfg_node_count <= n;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cur_n = n;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One graph over nodes 0..top: unloaded rows always sent, loaded ones mostly,
    // plus stray rows beyond top; the last mark may land on an unused node
    task automatic send_graph(input int top);
        int order [$];
        int extra;
        int j;
        int pick;
        int tmp;
        for (j = 0; j <= top; j++)
            if (!row_loaded[j] || $urandom_range(0, 99) < 85) order.insert(order.size(), j);
        if (top < NODES - 1) begin
            extra = $urandom_range(0, 2);
            repeat (extra) order.insert(order.size(), $urandom_range(top + 1, NODES - 1));
        end
        if (order.size() > 0 && $urandom_range(0, 9) == 0)
            order.insert(order.size(), order[$urandom_range(0, order.size() - 1)]);
        for (j = order.size() - 1; j > 0; j--) begin
            pick        = $urandom_range(0, j);
            tmp         = order[j];
            order[j]    = order[pick];
            order[pick] = tmp;
        end
        if ((top < NODES - 1 && $urandom_range(0, 9) == 0) || order.size() == 0)
            order.insert(order.size(), $urandom_range(top, NODES - 1));
        for (j = 0; j < order.size(); j++)
            send_row(IDX_W'(order[j]), random_row(top), j == order.size() - 1, 1'b0, '0);
    endtask

    // Output side: random stalls, plus one long hold-off while rows are still offered
    always @(negedge i_clk) begin
        if (!hold_done && results_seen >= HOLD_AFTER && i_in_valid) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (shut_left > 0) begin
            shut_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            shut_left = pick_gap(recv_calm);
        end
    end

    // Compare each closure row transfer with the oldest queued row
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (closure_q.size() == 0) begin
                report_mismatch("closure row with none queued", o_closure_row, '0);
            end else begin
                want_row = closure_q.pop_front();
                if (o_out_index !== want_row.idx)
                    report_mismatch("out_index", ROW_W'(o_out_index), ROW_W'(want_row.idx));
                if (o_closure_row !== want_row.row)
                    report_mismatch("closure_row", o_closure_row, want_row.row);
                if (o_last_out !== want_row.last)
                    report_mismatch("last_out", ROW_W'(o_last_out), ROW_W'(want_row.last));
            end
        end
    end

    // Run limit
    initial begin
        #40000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Stimulus
    initial begin
        int t;
        int phase_no;
        int top;
        int graphs;
        int roll;
        i_rst_n          = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_node_count = '0;
        i_in_valid       = 1'b0;
        i_row_index      = '0;
        i_row_bits       = '0;
        i_last_row       = 1'b0;
        i_out_stall      = 1'b1;
        cur_n            = NODE_COUNT_RST;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        for (t = 0; t < DIR_ROWS; t++) begin
            if (dir_tab[t].n != cur_n) set_node_count(dir_tab[t].n);
            send_row(dir_tab[t].idx, dir_tab[t].bits, dir_tab[t].last,
                     dir_tab[t].typed, dir_tab[t].every_row);
        end

        // Random graphs, mostly small, a few at the full size
        phase_no = 0;
        while (items_sent < RAND_ITEMS) begin
            case (phase_no)
                0: top = 63;
                1: top = 5;
                2: top = 0;
                3: top = 1;
                4: top = 30;
                5: top = 2;
                default: begin
                    roll = $urandom_range(0, 99);
                    if (roll < 70)      top = $urandom_range(1, 8);
                    else if (roll < 90) top = $urandom_range(9, 24);
                    else if (roll < 98) top = $urandom_range(25, 50);
                    else                top = 63;
                end
            endcase
            if (IDX_W'(top) != cur_n) set_node_count(IDX_W'(top));
            graphs = (top >= 32) ? 1 : $urandom_range(1, 4);
            repeat (graphs) send_graph(top);
            phase_no++;
        end
        i_in_valid <= 1'b0;

        while (closure_q.size() != 0) @(posedge i_clk);
        repeat (END_WAIT) @(posedge i_clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
